@@ rtl/key_auto_repeat_timer_core_defines.svh @@
// assertion macros for the key auto-repeat timer core
`ifndef KEY_AUTO_REPEAT_TIMER_CORE_DEFINES_SVH
`define KEY_AUTO_REPEAT_TIMER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on i_clk, off during reset
`define KRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("krt assertion failed");
// next-cycle implication, sampled on i_clk, off during reset
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("krt assertion failed");
`else
`define KRT_ASSERT_IMP(lbl, ante, cons)
`define KRT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/krt_pkg.sv @@
// shared types and constants for the key auto-repeat timer
package krt_pkg;

    localparam int HELD_KEY_SLOTS = 6;
    localparam int HELD_INPUTS    = 6;

    localparam logic [15:0] DELAY_RESET  = 16'd400;
    localparam logic [15:0] PERIOD_RESET = 16'd100;

    typedef logic [7:0]  t_key;
    typedef logic [15:0] t_ms;

    typedef enum logic [1:0] {
        OP_PRESS = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_INITIAL_DELAY = 2'd0,
        CFG_REPEAT_PERIOD = 2'd1
    } t_cfg_index;

    typedef struct packed {
        t_op  op;
        t_key code;
        t_key modifier;
    } t_cmd;

    typedef struct packed {
        logic success;
        t_key key;
        t_key modifier;
    } t_result;

endpackage

@@ rtl/key_auto_repeat_timer_core.sv @@
// top level of the key auto-repeat timer: handshake stages and config registers
//
//  channel   direction  handshake                 payload
//  in        into core  i_in_valid / o_in_stall   i_op, i_press_*, i_held_key_0..5
//  out       from core  o_out_valid / i_out_stall o_success, o_key_out, o_modifier_out
//  cfg       into core  i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled: an accepted transaction sits in the input register,
// goes through the key compare and countdown logic and lands in the result register
// the result is offered from the result register and stays there until the output takes it
// reset is synchronous and active low; it restores the 400 ms delay and 100 ms period
// the input stalls only when both the input and result registers are full and the
// output is stalled; config writes are always taken
module key_auto_repeat_timer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [7:0]          i_press_code,
    input  logic [7:0]          i_press_modifier,
    input  logic [7:0]          i_held_key_0,
    input  logic [7:0]          i_held_key_1,
    input  logic [7:0]          i_held_key_2,
    input  logic [7:0]          i_held_key_3,
    input  logic [7:0]          i_held_key_4,
    input  logic [7:0]          i_held_key_5,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_success,
    output logic [7:0]          o_key_out,
    output logic [7:0]          o_modifier_out,
    // config channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import krt_pkg::*;

    `include "key_auto_repeat_timer_core_defines.svh"

    // input register
    logic    r_in_valid;
    t_cmd    r_cmd;
    t_key    r_held [HELD_INPUTS];
    logic    in_take;
    logic    advance;

    // result register
    logic    r_out_valid;
    t_result r_res;
    t_result res;

    // config registers
    t_ms     r_delay;
    t_ms     r_period;

    logic    held_found;
    t_key    stored_key;

    // item leaves the input register when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload captured on acceptance only
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd     <= '{op: t_op'(i_op), code: i_press_code, modifier: i_press_modifier};
            r_held[0] <= i_held_key_0;
            r_held[1] <= i_held_key_1;
            r_held[2] <= i_held_key_2;
            r_held[3] <= i_held_key_3;
            r_held[4] <= i_held_key_4;
            r_held[5] <= i_held_key_5;
        end
    end

    krt_held_match u_match (
        .i_held       (r_held),
        .i_stored_key (stored_key),
        .o_found      (held_found)
    );

    krt_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (advance),
        .i_cmd           (r_cmd),
        .i_held_found    (held_found),
        .i_initial_delay (r_delay),
        .i_repeat_period (r_period),
        .o_stored_key    (stored_key),
        .o_result        (res)
    );

    // result register, held while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_success      = r_res.success;
    assign o_key_out      = r_res.key;
    assign o_modifier_out = r_res.modifier;

    // config writes, indexes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_INITIAL_DELAY) begin
                r_delay <= i_cfg_data;
            end else if (i_cfg_index == CFG_REPEAT_PERIOD) begin
                r_period <= i_cfg_data;
            end
        end
    end

    `KRT_ASSERT_IMP(a_stall_only_when_full, o_in_stall, r_in_valid && r_out_valid && i_out_stall)
    `KRT_ASSERT_NEXT(a_advance_fills_result, advance, r_out_valid)
    `KRT_ASSERT_NEXT(a_tick_no_success, advance && r_cmd.op == OP_TICK, !o_success)

endmodule

@@ rtl/krt_held_match.sv @@
// search of the zero-terminated held key list for the stored key
module krt_held_match (
    input  krt_pkg::t_key i_held [krt_pkg::HELD_INPUTS],
    input  krt_pkg::t_key i_stored_key,
    output logic          o_found
);
    import krt_pkg::*;

    always_comb begin
        logic alive;
        alive   = 1'b1;
        o_found = 1'b0;
        for (int i = 0; i < HELD_KEY_SLOTS && i < HELD_INPUTS; i++) begin
            if (i_held[i] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive && (i_held[i] == i_stored_key)) begin
                o_found = 1'b1;
            end
        end
    end

endmodule

@@ rtl/krt_engine.sv @@
// key store, ready mark and repeat countdown with per-item result
module krt_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  krt_pkg::t_cmd    i_cmd,
    input  logic             i_held_found,
    input  krt_pkg::t_ms     i_initial_delay,
    input  krt_pkg::t_ms     i_repeat_period,
    output krt_pkg::t_key    o_stored_key,
    output krt_pkg::t_result o_result
);
    import krt_pkg::*;

    `include "key_auto_repeat_timer_core_defines.svh"

    t_key r_key, n_key;
    t_key r_mod, n_mod;
    logic r_ready, n_ready;
    logic r_running, n_running;
    t_ms  r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_mod     <= '0;
            r_ready   <= 1'b0;
            r_running <= 1'b0;
            r_count   <= '0;
        end else begin
            r_key     <= n_key;
            r_mod     <= n_mod;
            r_ready   <= n_ready;
            r_running <= n_running;
            r_count   <= n_count;
        end
    end

    always_comb begin
        n_key     = r_key;
        n_mod     = r_mod;
        n_ready   = r_ready;
        n_running = r_running;
        n_count   = r_count;
        o_result  = '0;
        if (i_fire) begin
            unique case (i_cmd.op)
                OP_PRESS: begin
                    if (i_cmd.code != r_key) begin
                        n_key            = i_cmd.code;
                        n_mod            = i_cmd.modifier;
                        n_ready          = 1'b1;
                        n_running        = 1'b1;
                        n_count          = i_initial_delay;
                        o_result.success = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (r_running) begin
                        if (r_count > 16'd1) begin
                            n_count = r_count - 16'd1;
                        end else if (i_held_found) begin
                            n_ready = 1'b1;
                            n_count = i_repeat_period;
                        end else begin
                            n_running = 1'b0;
                            n_count   = '0;
                        end
                    end
                end
                OP_READ: begin
                    if (r_ready) begin
                        n_ready           = 1'b0;
                        o_result.success  = 1'b1;
                        o_result.key      = r_key;
                        o_result.modifier = r_mod;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stored_key = r_key;

    `KRT_ASSERT_IMP(a_idle_count_zero, !r_running, r_count == 16'd0)
    `KRT_ASSERT_NEXT(a_read_clears_ready, i_fire && i_cmd.op == OP_READ && r_ready, !r_ready)
    `KRT_ASSERT_NEXT(a_new_press_arms, i_fire && i_cmd.op == OP_PRESS && i_cmd.code != r_key,
        r_running && r_ready)

endmodule
